// ===== sv/lru_key_list_core_defines.svh =====
// Assertion macros shared by the checker of the key list core
`ifndef LRU_KEY_LIST_CORE_DEFINES_SVH
`define LRU_KEY_LIST_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during rst
`define LKL_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) else $error(msg);

// Next-cycle implication, sampled on clk and held off during rst
`define LKL_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) else $error(msg);

`endif

// ===== sv/lkl_pkg.sv =====
// Shared types and constants of the key list core
package lkl_pkg;

  localparam int KEY_W = 32;
  localparam int OCC_W = 4;
  localparam int OP_W  = 2;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // How the slot row moves for one transaction
  typedef struct packed {
    logic shift_in;   // open slot 0 for the new key, close the gap at the match
    logic shift_out;  // pull entries above the match down by one
  } lkl_move_t;

endpackage

// ===== sv/lru_key_list_core.sv =====
// Top level of the least-recently-used key list
// Usage:
//   Slave channel s_*: one transaction per operation. s_tuser carries the
//   op code (insert, delete, search and promote), s_tdata the 32-bit key.
//   Master channel m_*: exactly one result transaction per operation, in
//   order: hit, evicted, evicted key (zero when nothing was dropped) and
//   the occupancy after the operation, modulo 16.
// Path: an accepted operation is held in the input register, then loads
//   the result register as soon as that register is empty or being taken.
// Throughput: one operation per cycle while m_tready is high. The compare
//   over all CAPACITY slots and the one-step reorder of the slot row sit
//   between the input and result registers, and the list state updates on
//   the same edge that loads the result, so the next operation sees it.
// Reset: rst clears the occupancy and both valid flags; slot contents are
//   not cleared, only slots below the occupancy are ever compared.
// Stall: while m_tready is low the result holds; one more operation waits
//   in the input register, then s_tready drops until the result is taken.
module lru_key_list_core #(
  parameter int CAPACITY = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key
  input  logic [1:0]  s_tuser,   // [1:0] op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [0] hit, [1] evicted, [33:2] evicted_key,
                                 // [37:34] occupancy, [39:38] zero
);
  import lkl_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);

  // input register
  logic             in_valid;
  logic [OP_W-1:0]  in_op;
  logic [KEY_W-1:0] in_key;

  // list state
  logic [CAPACITY-1:0][KEY_W-1:0] slots;
  logic [CAPACITY-1:0][KEY_W-1:0] slots_next;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               count_next;

  // result register
  logic             out_valid;
  logic             out_hit;
  logic             out_evicted;
  logic [KEY_W-1:0] out_evicted_key;
  logic [OCC_W-1:0] out_occupancy;

  logic                advance;
  logic                work;
  logic                hit;
  logic                hit_result;
  logic                full;
  logic                evict;
  logic [CAPACITY-1:0] match_at_or_before;
  lkl_move_t           move;
  logic [CNT_W+OCC_W-1:0] occ_wide;

  // result register frees up when empty or taken this cycle
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;
  assign work     = in_valid && advance;
  assign full     = (count == CNT_W'(CAPACITY));

  lkl_match #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_match (
    .slots              (slots),
    .count              (count),
    .key                (in_key),
    .match_at_or_before (match_at_or_before),
    .hit                (hit)
  );

  // decode the operation into row movement and occupancy change
  always_comb begin
    move       = '0;
    count_next = count;
    hit_result = 1'b0;
    evict      = 1'b0;
    case (in_op)
      OP_INSERT: begin
        move.shift_in = 1'b1;
        hit_result    = hit;
        // a miss on a full list drops the tail slot
        evict         = !hit && full;
        if (!hit && !full) begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        move.shift_out = hit;
        hit_result     = hit;
        if (hit) begin
          count_next = count - CNT_W'(1);
        end
      end
      OP_SEARCH: begin
        move.shift_in = hit;
        hit_result    = hit;
      end
      default: begin
        // unused code: no change, hit reads as zero
        move = '0;
      end
    endcase
  end

  lkl_shift #(
    .CAPACITY (CAPACITY)
  ) u_shift (
    .slots              (slots),
    .key                (in_key),
    .match_at_or_before (match_at_or_before),
    .move               (move),
    .slots_next         (slots_next)
  );

  // occupancy is reported modulo 16
  assign occ_wide = {{OCC_W{1'b0}}, count_next};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
      if (work) begin
        count <= count_next;
      end
    end
  end

  // payload: hold input, commit list and result
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op  <= s_tuser;
      in_key <= s_tdata;
    end
    if (work) begin
      slots           <= slots_next;
      out_hit         <= hit_result;
      out_evicted     <= evict;
      out_evicted_key <= evict ? slots[CAPACITY-1] : '0;
      out_occupancy   <= occ_wide[OCC_W-1:0];
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_occupancy, out_evicted_key, out_evicted, out_hit};

endmodule

// ===== sv/lkl_match.sv =====
// Associative compare of one key against every held slot
module lkl_match #(
  parameter int CAPACITY = 8,
  parameter int CNT_W    = 4
) (
  input  logic [CAPACITY-1:0][lkl_pkg::KEY_W-1:0] slots,
  input  logic [CNT_W-1:0]                        count,
  input  logic [lkl_pkg::KEY_W-1:0]               key,
  output logic [CAPACITY-1:0]                     match_at_or_before,
  output logic                                    hit
);
  import lkl_pkg::*;

  logic [CAPACITY-1:0] match;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    assign match[i]              = (count > CNT_W'(i)) && (slots[i] == key);
    assign match_at_or_before[i] = |match[i:0];
  end

  assign hit = |match;

endmodule

// ===== sv/lkl_shift.sv =====
// Next contents of the slot row: push to front, or close a gap
module lkl_shift #(
  parameter int CAPACITY = 8
) (
  input  logic [CAPACITY-1:0][lkl_pkg::KEY_W-1:0] slots,
  input  logic [lkl_pkg::KEY_W-1:0]               key,
  input  logic [CAPACITY-1:0]                     match_at_or_before,
  input  lkl_pkg::lkl_move_t                      move,
  output logic [CAPACITY-1:0][lkl_pkg::KEY_W-1:0] slots_next
);
  import lkl_pkg::*;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    logic [KEY_W-1:0] from_front;
    logic [KEY_W-1:0] from_back;

    if (i == 0) begin : g_head
      assign from_front = key;
    end else begin : g_body
      // shift down only up to and including the matched slot
      assign from_front = match_at_or_before[i-1] ? slots[i] : slots[i-1];
    end

    if (i < CAPACITY - 1) begin : g_pull
      assign from_back = match_at_or_before[i] ? slots[i+1] : slots[i];
    end else begin : g_last
      assign from_back = slots[i];
    end

    assign slots_next[i] = move.shift_in  ? from_front :
                           move.shift_out ? from_back  : slots[i];
  end

endmodule

// ===== sv/lkl_checker.sv =====
// Port-level checker of the key list core, bound to the top level
module lkl_checker #(
  parameter int CAPACITY = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);
  `include "lru_key_list_core_defines.svh"

  localparam logic [3:0] OCC_FULL = 4'(CAPACITY % 16);
  localparam logic       WRAPS    = (CAPACITY >= 16);

  // a stalled result holds its value
  `LKL_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed under stall")

  // an eviction only on a miss that leaves the list full
  `LKL_ASSERT_IMP(a_evict, m_tvalid && m_tdata[1], !m_tdata[0] && (m_tdata[37:34] == OCC_FULL), "eviction on hit or non-full list")

  // no eviction means a zero evicted key
  `LKL_ASSERT_IMP(a_evkey, m_tvalid && !m_tdata[1], m_tdata[33:2] == 32'd0, "evicted key not zero")

  // occupancy never exceeds capacity (checked only when capacity is below 16)
  `LKL_ASSERT_IMP(a_occ, m_tvalid && !WRAPS, m_tdata[37:34] <= OCC_FULL, "occupancy above capacity")

endmodule

bind lru_key_list_core lkl_checker #(
  .CAPACITY (CAPACITY)
) u_lkl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
